// File: hdl/fmhc_pkg.sv
package fmhc_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int CNT_W        = 17;

	typedef logic [CNT_W-1:0] count_t;

	// Header offsets; the sum covers every header byte from OFF_TYPE onward.
	localparam count_t OFF_TAG_LAST = count_t'(1);
	localparam count_t OFF_VER_LAST = count_t'(3);
	localparam count_t OFF_SUM      = count_t'(4);
	localparam count_t OFF_TYPE     = count_t'(5);
	localparam count_t OFF_SEQ_LAST = count_t'(9);
	localparam count_t OFF_LEN_LAST = count_t'(11);
	localparam count_t SUM_START    = count_t'(5);
	localparam count_t HDR_END      = count_t'(HEADER_BYTES);

	typedef enum logic {
		OP_DATA    = 1'b0,
		OP_RESTART = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		PH_PENDING = 2'd0,
		PH_HEADER  = 2'd1,
		PH_BODY    = 2'd2,
		PH_ERROR   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_TAG   = 2'd1,
		ERR_SUM   = 2'd2,
		ERR_EXTRA = 2'd3
	} err_t;

endpackage

// File: hdl/fmhc_in_if.sv
interface fmhc_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

// File: hdl/fmhc_out_if.sv
interface fmhc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  parse_state;
	logic [1:0]  error_kind;
	logic        frame_done;
	logic [7:0]  body_byte;
	logic        body_byte_valid;
	logic [15:0] version;
	logic [7:0]  command_type;
	logic [31:0] sequence_number;
	logic [15:0] body_length;

	modport source (
		output valid, output parse_state, output error_kind, output frame_done,
		output body_byte, output body_byte_valid, output version,
		output command_type, output sequence_number, output body_length,
		input ready
	);
	modport sink (
		input valid, input parse_state, input error_kind, input frame_done,
		input body_byte, input body_byte_valid, input version,
		input command_type, input sequence_number, input body_length,
		output ready
	);
endinterface

// File: hdl/fmhc_cfg_if.sv
interface fmhc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] start_tag;

	modport source (output valid, output start_tag, input ready);
	modport sink (input valid, input start_tag, output ready);
endinterface

// File: hdl/framed_message_header_checker.sv
// Channel | Direction | Payload
// din     | in        | opcode, data_byte
// dout    | out       | parse_state, error_kind, frame_done, body_byte, body_byte_valid,
//         |           | version, command_type, sequence_number, body_length
// cfg     | in        | start_tag (always ready)
//
// One transaction per cycle unless dout stalls; dout offers results from the result register.
// The frame state is updated as a byte moves from the input register into the
// result register, so the running sum and byte counter feed back with no extra register.
// Reset clears the frame state, start_tag and the valid flags of both register stages.
// A stall on dout holds the result; the input register still takes one more byte.
module framed_message_header_checker (
	input  logic         clk,
	input  logic         arst_n,
	fmhc_in_if.sink      din,
	fmhc_out_if.source   dout,
	fmhc_cfg_if.sink     cfg
);

	logic [15:0] start_tag_q;

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;

	logic        advance;

	fmhc_pkg::phase_t phase_q, phase_n;
	fmhc_pkg::err_t   err_q, err_n;
	fmhc_pkg::count_t count_q, count_n, count_inc, body_end;
	logic [15:0] tag_q, tag_n;
	logic [15:0] ver_q, ver_n;
	logic [7:0]  exp_sum_q, exp_sum_n;
	logic [7:0]  type_q, type_n;
	logic [31:0] seq_q, seq_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  sum_q, sum_n;
	logic        done_n;
	logic        bvalid_n;

	logic        fields_ok;
	logic [7:0]  body_byte_n;

	logic                valid_s2;
	fmhc_pkg::phase_t    phase_s2;
	fmhc_pkg::err_t      err_s2;
	logic                done_s2;
	logic [7:0]          body_byte_s2;
	logic                bvalid_s2;
	logic [15:0]         ver_s2;
	logic [7:0]          type_s2;
	logic [31:0]         seq_s2;
	logic [15:0]         len_s2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_tag_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			start_tag_q <= cfg.start_tag;
		end
	end

	assign advance   = valid_s1 && (!valid_s2 || dout.ready);
	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			op_s1   <= din.opcode;
			byte_s1 <= din.data_byte;
		end
	end

	assign count_inc = count_q + fmhc_pkg::count_t'(1);
	assign body_end  = fmhc_pkg::count_t'(len_q) + fmhc_pkg::HDR_END;

	// Next frame state for the byte held in the input register.
	always_comb begin
		phase_n   = phase_q;
		err_n     = err_q;
		count_n   = count_q;
		tag_n     = tag_q;
		ver_n     = ver_q;
		exp_sum_n = exp_sum_q;
		type_n    = type_q;
		seq_n     = seq_q;
		len_n     = len_q;
		sum_n     = sum_q;
		done_n    = 1'b0;
		bvalid_n  = 1'b0;
		if (op_s1 == fmhc_pkg::OP_RESTART) begin
			phase_n   = fmhc_pkg::PH_PENDING;
			err_n     = fmhc_pkg::ERR_NONE;
			count_n   = '0;
			tag_n     = '0;
			ver_n     = '0;
			exp_sum_n = '0;
			type_n    = '0;
			seq_n     = '0;
			len_n     = '0;
			sum_n     = '0;
		end else begin
			case (phase_q)
				fmhc_pkg::PH_PENDING: begin
					if (count_q <= fmhc_pkg::OFF_TAG_LAST) begin
						tag_n = {tag_q[7:0], byte_s1};
					end else if (count_q <= fmhc_pkg::OFF_VER_LAST) begin
						ver_n = {ver_q[7:0], byte_s1};
					end else if (count_q == fmhc_pkg::OFF_SUM) begin
						exp_sum_n = byte_s1;
					end else if (count_q == fmhc_pkg::OFF_TYPE) begin
						type_n = byte_s1;
					end else if (count_q <= fmhc_pkg::OFF_SEQ_LAST) begin
						seq_n = {seq_q[23:0], byte_s1};
					end else if (count_q <= fmhc_pkg::OFF_LEN_LAST) begin
						len_n = {len_q[7:0], byte_s1};
					end
					if (count_q >= fmhc_pkg::SUM_START) begin
						sum_n = sum_q + byte_s1;
					end
					count_n = count_inc;
					if (count_inc >= fmhc_pkg::HDR_END) begin
						if (tag_n != start_tag_q) begin
							phase_n = fmhc_pkg::PH_ERROR;
							err_n   = fmhc_pkg::ERR_TAG;
						end else if (len_n == 16'd0) begin
							phase_n = fmhc_pkg::PH_BODY;
							done_n  = 1'b1;
						end else begin
							phase_n = fmhc_pkg::PH_HEADER;
						end
					end
				end
				fmhc_pkg::PH_HEADER: begin
					bvalid_n = 1'b1;
					sum_n    = sum_q + byte_s1;
					count_n  = count_inc;
					if (count_inc >= body_end) begin
						if (sum_n == exp_sum_q) begin
							phase_n = fmhc_pkg::PH_BODY;
							done_n  = 1'b1;
						end else begin
							phase_n = fmhc_pkg::PH_ERROR;
							err_n   = fmhc_pkg::ERR_SUM;
						end
					end
				end
				fmhc_pkg::PH_BODY: begin
					phase_n = fmhc_pkg::PH_ERROR;
					err_n   = fmhc_pkg::ERR_EXTRA;
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	// Header fields are hidden until the tag has matched.
	always_comb begin
		fields_ok = (phase_n == fmhc_pkg::PH_HEADER) || (phase_n == fmhc_pkg::PH_BODY) ||
			((phase_n == fmhc_pkg::PH_ERROR) && (err_n != fmhc_pkg::ERR_TAG));
		body_byte_n = bvalid_n ? byte_s1 : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fmhc_pkg::PH_PENDING;
			err_q     <= fmhc_pkg::ERR_NONE;
			count_q   <= '0;
			tag_q     <= '0;
			ver_q     <= '0;
			exp_sum_q <= '0;
			type_q    <= '0;
			seq_q     <= '0;
			len_q     <= '0;
			sum_q     <= '0;
		end else if (advance) begin
			phase_q   <= phase_n;
			err_q     <= err_n;
			count_q   <= count_n;
			tag_q     <= tag_n;
			ver_q     <= ver_n;
			exp_sum_q <= exp_sum_n;
			type_q    <= type_n;
			seq_q     <= seq_n;
			len_q     <= len_n;
			sum_q     <= sum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (dout.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_s2     <= phase_n;
			err_s2       <= err_n;
			done_s2      <= done_n;
			body_byte_s2 <= body_byte_n;
			bvalid_s2    <= bvalid_n;
			ver_s2       <= fields_ok ? ver_n : 16'd0;
			type_s2      <= fields_ok ? type_n : 8'd0;
			seq_s2       <= fields_ok ? seq_n : 32'd0;
			len_s2       <= fields_ok ? len_n : 16'd0;
		end
	end

	assign dout.valid           = valid_s2;
	assign dout.parse_state     = phase_s2;
	assign dout.error_kind      = err_s2;
	assign dout.frame_done      = done_s2;
	assign dout.body_byte       = body_byte_s2;
	assign dout.body_byte_valid = bvalid_s2;
	assign dout.version         = ver_s2;
	assign dout.command_type    = type_s2;
	assign dout.sequence_number = seq_s2;
	assign dout.body_length     = len_s2;

	a_err_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((phase_s2 == fmhc_pkg::PH_ERROR) == (err_s2 != fmhc_pkg::ERR_NONE)))
		else $error("error kind disagrees with parse state");

	a_done_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> (phase_s2 == fmhc_pkg::PH_BODY))
		else $error("frame done outside body valid");

	a_bvalid_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && bvalid_s2) |-> ((phase_s2 == fmhc_pkg::PH_HEADER) ||
			(phase_s2 == fmhc_pkg::PH_BODY) ||
			((phase_s2 == fmhc_pkg::PH_ERROR) && (err_s2 == fmhc_pkg::ERR_SUM))))
		else $error("body byte flagged in wrong phase");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (phase_q == fmhc_pkg::PH_ERROR) && (op_s1 == fmhc_pkg::OP_DATA))
		|=> (phase_q == fmhc_pkg::PH_ERROR) && $stable(err_q))
		else $error("error left without restart");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !dout.ready) |=> valid_s2 && $stable(seq_s2) && $stable(phase_s2))
		else $error("stalled result changed");

endmodule
